// ----- design/assert_macros.svh -----
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PFP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PFP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PFP_ASSERT(lbl, clk, rst, prop, msg)
`define PFP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- design/pfp_pkg.sv -----
// Shared constants and types for the plane-from-three-points pipeline.
package pfp_pkg;
   localparam int COORD_FRAC_BITS = 16;
   localparam int D_FRAC_BITS     = 16;
   localparam int KPOS = (D_FRAC_BITS >= COORD_FRAC_BITS) ? D_FRAC_BITS - COORD_FRAC_BITS : 0;
   localparam int KNEG = (COORD_FRAC_BITS > D_FRAC_BITS) ? COORD_FRAC_BITS - D_FRAC_BITS : 0;
   localparam int MAG_W   = 66;
   localparam int BL_W    = 7;
   localparam int N_W     = 30;
   localparam int SQ_W    = 62;
   localparam int DOT_W   = 64;
   localparam int ROOT_W  = 31;
   localparam int NUM_W   = 64 + KPOS;
   localparam int DEN_W   = 31 + KNEG;
   localparam int QW      = 49;
   localparam int SQRT_STAGES  = 32;
   localparam int FRONT_STAGES = 8;
   localparam int LAT = FRONT_STAGES + SQRT_STAGES + QW + 1;

   typedef struct packed {
      logic [2:0] neg;
      logic       dot_pos;
      logic       degen;
   } side_type;

   typedef struct packed {
      logic [2:0][N_W-1:0] nmag;
      logic [DOT_W-2:0]    dm;
      side_type            side;
   } carry_type;
endpackage

// ----- design/plane_from_three_points_top.sv -----
// Top level of the plane-from-three-points pipeline.
// Plane through three points: unit normal (a, b, c) and offset d so that
// a*x + b*y + c*z + d = 0.
// Input channel req_: one item carries three points, nine signed Q16.16
// coordinates. Result channel rsp_: one item per input item, in order, with
// a, b, c in signed Q2.30 and d in signed Q32.16; rsp_tuser is the
// degenerate flag, set for collinear or coincident points (all data zero).
// The pipeline runs edge vectors and cross product, then normalization,
// squares and dot product, then the bit-per-stage square root, then the
// bit-per-stage dividers and one output register. Throughput is one item
// per cycle while the output is not stalled.
// When rsp_tready is low with a result shown, the whole pipeline holds and
// req_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears every valid bit.
`include "assert_macros.svh"

module plane_from_three_points_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // p0_x, p0_y, p0_z, p1_x, p1_y, p1_z, p2_x, p2_y, p2_z (32 bits each)
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // a_coef[31:0], b_coef[63:32], c_coef[95:64], d_coef[143:96]
   output logic [143:0] rsp_tdata,
   // degenerate
   output logic         rsp_tuser
);
   import pfp_pkg::*;

   logic en;
   logic [LAT-1:0] valid_ff;
   logic [2:0][31:0] p0, p1, p2, p0_c;
   logic [2:0][MAG_W-1:0] mag;
   logic [2:0] neg;
   logic [SQ_W-1:0] sum_sq;
   carry_type carry_n;
   carry_type dl_ff [SQRT_STAGES];
   side_type  sd_ff [QW];
   logic [ROOT_W-1:0] root;
   logic [NUM_W-1:0] num [4];
   logic [DEN_W-1:0] den [4];
   logic [QW-1:0] quo [4];
   logic ovf [4];
   logic [QW:0] qr [4];
   logic [31:0] coef_in [3];
   logic [47:0] d_in;
   logic [QW-1:0] dq;
   logic [143:0] data_ff, data_in;
   logic user_ff;
   side_type so;

   // one global advance: move everything while the output slot is free or taken
   assign en         = !valid_ff[LAT-1] || rsp_tready;
   assign req_tready = en;

   for (genvar i = 0; i < 3; i++) begin : g_unpack
      assign p0[i] = req_tdata[32*i +: 32];
      assign p1[i] = req_tdata[96 + 32*i +: 32];
      assign p2[i] = req_tdata[192 + 32*i +: 32];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], req_tvalid};
      end
   end

   pfp_cross u_cross (
      .clock(clock), .en(en), .p0(p0), .p1(p1), .p2(p2),
      .mag(mag), .neg(neg), .p0_out(p0_c)
   );

   pfp_norm u_norm (
      .clock(clock), .en(en), .mag(mag), .neg(neg), .p0(p0_c),
      .sum_sq(sum_sq), .carry(carry_n)
   );

   pfp_sqrt u_sqrt (.clock(clock), .en(en), .rad(sum_sq), .root(root));

   // hold normalized components beside the root unit
   always_ff @(posedge clock) begin
      if (en) begin
         dl_ff[0] <= carry_n;
         for (int i = 1; i < SQRT_STAGES; i++) dl_ff[i] <= dl_ff[i-1];
         sd_ff[0] <= dl_ff[SQRT_STAGES-1].side;
         for (int i = 1; i < QW; i++) sd_ff[i] <= sd_ff[i-1];
      end
   end

   // dividers form twice the quotient so rounding is one add and a shift
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         num[i] = NUM_W'({dl_ff[SQRT_STAGES-1].nmag[i], 31'b0});
         den[i] = DEN_W'(root);
      end
      num[3] = NUM_W'({dl_ff[SQRT_STAGES-1].dm, 1'b0}) << KPOS;
      den[3] = DEN_W'(root) << KNEG;
   end

   for (genvar i = 0; i < 4; i++) begin : g_div
      pfp_div u_div (
         .clock(clock), .en(en), .num(num[i]), .den(den[i]),
         .quo(quo[i]), .ovf(ovf[i])
      );
      assign qr[i] = ({1'b0, quo[i]} + (QW+1)'(1)) >> 1;
   end

   assign so = sd_ff[QW-1];
   assign dq = qr[3][QW-1:0];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         coef_in[i] = so.neg[i] ? -qr[i][31:0] : qr[i][31:0];
      end
      // clamp d to the signed 48-bit range
      if (so.dot_pos) begin
         if (ovf[3] || dq > QW'(48'h8000_0000_0000)) d_in = 48'h8000_0000_0000;
         else d_in = -dq[47:0];
      end else begin
         if (ovf[3] || dq > QW'(48'h7FFF_FFFF_FFFF)) d_in = 48'h7FFF_FFFF_FFFF;
         else d_in = dq[47:0];
      end
      if (so.degen) data_in = '0;
      else data_in = {d_in, coef_in[2], coef_in[1], coef_in[0]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
         user_ff <= so.degen;
      end
   end

   assign rsp_tvalid = valid_ff[LAT-1];
   assign rsp_tdata  = data_ff;
   assign rsp_tuser  = user_ff;

   `PFP_ASSERT(a_degen_zero, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata == '0, "degenerate result carries nonzero data")
   `PFP_ASSERT(a_unit_range, clock, reset, rsp_tvalid && !rsp_tuser |-> $signed(rsp_tdata[31:0]) <= 32'sh4000_0000 && $signed(rsp_tdata[31:0]) >= -32'sh4000_0000, "a_coef outside unit range")
   `PFP_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid right after reset")
endmodule

// ----- design/pfp_cross.sv -----
// Edge vectors and exact cross product, three register stages.
module pfp_cross (
   input  logic                      clock,
   input  logic                      en,
   input  logic [2:0][31:0]          p0,
   input  logic [2:0][31:0]          p1,
   input  logic [2:0][31:0]          p2,
   output logic [2:0][pfp_pkg::MAG_W-1:0] mag,
   output logic [2:0]                neg,
   output logic [2:0][31:0]          p0_out
);
   import pfp_pkg::*;

   logic signed [32:0] e1_ff [3], e2_ff [3], e1_in [3], e2_in [3];
   logic signed [65:0] pa_ff [3], pb_ff [3], pa_in [3], pb_in [3];
   logic [2:0][31:0] p0a_ff, p0b_ff, p0c_ff;
   logic [2:0][MAG_W-1:0] mag_ff, mag_in;
   logic [2:0] neg_ff, neg_in;
   logic signed [66:0] cr [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = $signed({p1[i][31], p1[i]}) - $signed({p0[i][31], p0[i]});
         e2_in[i] = $signed({p2[i][31], p2[i]}) - $signed({p0[i][31], p0[i]});
      end
      // y1*z2 - z1*y2, z1*x2 - x1*z2, x1*y2 - y1*x2
      pa_in[0] = e1_ff[1] * e2_ff[2];  pb_in[0] = e1_ff[2] * e2_ff[1];
      pa_in[1] = e1_ff[2] * e2_ff[0];  pb_in[1] = e1_ff[0] * e2_ff[2];
      pa_in[2] = e1_ff[0] * e2_ff[1];  pb_in[2] = e1_ff[1] * e2_ff[0];
      for (int i = 0; i < 3; i++) begin
         cr[i] = $signed({pa_ff[i][65], pa_ff[i]}) - $signed({pb_ff[i][65], pb_ff[i]});
         neg_in[i] = cr[i][66];
         mag_in[i] = cr[i][66] ? MAG_W'(-cr[i]) : MAG_W'(cr[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         e1_ff  <= e1_in;
         e2_ff  <= e2_in;
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         mag_ff <= mag_in;
         neg_ff <= neg_in;
         p0a_ff <= p0;
         p0b_ff <= p0a_ff;
         p0c_ff <= p0b_ff;
      end
   end

   assign mag    = mag_ff;
   assign neg    = neg_ff;
   assign p0_out = p0c_ff;
endmodule

// ----- design/pfp_norm.sv -----
// Block normalization, squares, offset dot product, five register stages.
module pfp_norm (
   input  logic                         clock,
   input  logic                         en,
   input  logic [2:0][pfp_pkg::MAG_W-1:0] mag,
   input  logic [2:0]                   neg,
   input  logic [2:0][31:0]             p0,
   output logic [pfp_pkg::SQ_W-1:0]     sum_sq,
   output pfp_pkg::carry_type           carry
);
   import pfp_pkg::*;

   // stage 4: bit length of the largest magnitude
   logic [BL_W-1:0] bl_ff, bl_in;
   logic [2:0][MAG_W-1:0] mag4_ff;
   logic [2:0] neg4_ff, neg5_ff, neg6_ff, neg7_ff;
   logic [2:0][31:0] p04_ff, p05_ff;
   logic [MAG_W-1:0] all_or;
   // stage 5: shifted magnitudes
   logic [2:0][N_W-1:0] n5_ff, n5_in, n6_ff, n7_ff, n8_ff;
   logic [MAG_W+N_W-1:0] shw [3];
   logic degen5_ff, degen6_ff, degen7_ff, degen8_ff;
   // stage 6: squares and dot terms
   logic [2*N_W-1:0] sq_ff [3], sq_in [3];
   logic signed [N_W:0] nsig [3];
   logic signed [62:0] dp_ff [3], dp_in [3];
   // stage 7: sums
   logic [SQ_W-1:0] sum7_ff, sum7_in, sum8_ff;
   logic signed [DOT_W-1:0] dot_ff, dot_in;
   // stage 8: magnitude of the dot product
   logic [DOT_W-2:0] dm_ff, dm_in;
   logic dpos_ff, dpos_in;
   logic [2:0] neg8_ff;

   always_comb begin
      all_or = mag[0] | mag[1] | mag[2];
      bl_in = '0;
      for (int i = 0; i < MAG_W; i++) begin
         if (all_or[i]) bl_in = BL_W'(i + 1);
      end
      for (int i = 0; i < 3; i++) begin
         shw[i] = {mag4_ff[i], {N_W{1'b0}}} >> bl_ff;
         n5_in[i] = shw[i][N_W-1:0];
         nsig[i] = neg5_ff[i] ? -$signed({1'b0, n5_ff[i]}) : $signed({1'b0, n5_ff[i]});
         sq_in[i] = n5_ff[i] * n5_ff[i];
         dp_in[i] = nsig[i] * $signed(p05_ff[i]);
      end
      sum7_in = SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);
      dot_in  = dp_ff[0] + dp_ff[1] + dp_ff[2];
      dm_in   = dot_ff[DOT_W-1] ? (DOT_W-1)'(-dot_ff) : (DOT_W-1)'(dot_ff);
      dpos_in = !dot_ff[DOT_W-1] && (dot_ff != '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         bl_ff     <= bl_in;
         mag4_ff   <= mag;
         neg4_ff   <= neg;
         p04_ff    <= p0;
         n5_ff     <= n5_in;
         neg5_ff   <= neg4_ff;
         p05_ff    <= p04_ff;
         degen5_ff <= (bl_ff == '0);
         sq_ff     <= sq_in;
         dp_ff     <= dp_in;
         n6_ff     <= n5_ff;
         neg6_ff   <= neg5_ff;
         degen6_ff <= degen5_ff;
         sum7_ff   <= sum7_in;
         dot_ff    <= dot_in;
         n7_ff     <= n6_ff;
         neg7_ff   <= neg6_ff;
         degen7_ff <= degen6_ff;
         sum8_ff   <= sum7_ff;
         dm_ff     <= dm_in;
         dpos_ff   <= dpos_in;
         n8_ff     <= n7_ff;
         neg8_ff   <= neg7_ff;
         degen8_ff <= degen7_ff;
      end
   end

   assign sum_sq             = sum8_ff;
   assign carry.nmag         = n8_ff;
   assign carry.dm           = dm_ff;
   assign carry.side.neg     = neg8_ff;
   assign carry.side.dot_pos = dpos_ff;
   assign carry.side.degen   = degen8_ff;
endmodule

// ----- design/pfp_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
module pfp_sqrt (
   input  logic                        clock,
   input  logic                        en,
   input  logic [pfp_pkg::SQ_W-1:0]    rad,
   output logic [pfp_pkg::ROOT_W-1:0]  root
);
   import pfp_pkg::*;

   logic [62:0] v_ff [SQRT_STAGES], r_ff [SQRT_STAGES];
   logic [62:0] v_in [SQRT_STAGES], r_in [SQRT_STAGES];

   for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_st
      logic [62:0] vp, rp, bt, tr;
      if (i == 0) begin : g_first
         assign vp = {1'b0, rad};
         assign rp = '0;
      end else begin : g_next
         assign vp = v_ff[i-1];
         assign rp = r_ff[i-1];
      end
      assign bt = 63'(1) << (2 * (SQRT_STAGES - 1 - i));
      assign tr = rp + bt;
      always_comb begin
         if (vp >= tr) begin
            v_in[i] = vp - tr;
            r_in[i] = (rp >> 1) + bt;
         end else begin
            v_in[i] = vp;
            r_in[i] = rp >> 1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[i] <= v_in[i];
            r_ff[i] <= r_in[i];
         end
      end
   end

   assign root = r_ff[SQRT_STAGES-1][ROOT_W-1:0];
endmodule

// ----- design/pfp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module pfp_div (
   input  logic                       clock,
   input  logic                       en,
   input  logic [pfp_pkg::NUM_W-1:0]  num,
   input  logic [pfp_pkg::DEN_W-1:0]  den,
   output logic [pfp_pkg::QW-1:0]     quo,
   output logic                       ovf
);
   import pfp_pkg::*;

   localparam int HI_W = NUM_W - QW;

   logic [DEN_W-1:0] rem_ff [QW], rem_in [QW], den_ff [QW];
   logic [QW-1:0]    nq_ff [QW], nq_in [QW];
   logic             ov_ff [QW];
   logic [HI_W-1:0]  hi;
   logic             ov0;
   logic [DEN_W-1:0] rem0;

   assign hi   = num[NUM_W-1:QW];
   assign ov0  = ({{DEN_W{1'b0}}, hi} >= {{HI_W{1'b0}}, den});
   assign rem0 = ov0 ? '0 : DEN_W'(hi);

   for (genvar i = 0; i < QW; i++) begin : g_st
      logic [DEN_W-1:0] rp, dp;
      logic [QW-1:0]    qp;
      logic             op;
      logic [DEN_W:0]   t;
      logic             ge;
      if (i == 0) begin : g_first
         assign rp = rem0;
         assign qp = num[QW-1:0];
         assign dp = den;
         assign op = ov0;
      end else begin : g_next
         assign rp = rem_ff[i-1];
         assign qp = nq_ff[i-1];
         assign dp = den_ff[i-1];
         assign op = ov_ff[i-1];
      end
      assign t  = {rp, qp[QW-1]};
      assign ge = (t >= {1'b0, dp});
      assign rem_in[i] = ge ? DEN_W'(t - {1'b0, dp}) : DEN_W'(t);
      assign nq_in[i]  = {qp[QW-2:0], ge};
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[i] <= rem_in[i];
            nq_ff[i]  <= nq_in[i];
            den_ff[i] <= dp;
            ov_ff[i]  <= op;
         end
      end
   end

   assign quo = nq_ff[QW-1];
   assign ovf = ov_ff[QW-1];
endmodule

// ----- verif/tb_plane_from_three_points_top.sv -----
// Testbench for the plane-from-three-points pipeline: random and corner triples, scoreboard check.
`timescale 1ns / 1ps

module tb_plane_from_three_points_top;
   import pfp_pkg::*;

   typedef struct {
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [31:0] c;
      logic signed [47:0] d;
      logic               degen;
   } plane_type;

   // Exact fixed-point plane through three points, kept in wide signed vectors.
   function automatic plane_type plane_of(input logic [287:0] pts);
      plane_type r;
      logic signed [31:0] p [9];
      logic signed [33:0] e1 [3];
      logic signed [33:0] e2 [3];
      logic signed [69:0] cr [3];
      logic [69:0] mag [3];
      logic [63:0] m [3];
      logic signed [63:0] n [3];
      logic [63:0] sum;
      logic [63:0] root;
      logic [63:0] rem;
      logic [63:0] bitv;
      logic signed [127:0] dot;
      logic [127:0] dmag;
      logic [127:0] q;
      logic [127:0] rr;
      logic [127:0] lim;
      int maxlen;
      int sh;
      for (int i = 0; i < 9; i++) p[i] = pts[32*i +: 32];
      for (int i = 0; i < 3; i++) begin
         e1[i] = 34'(p[3+i]) - 34'(p[i]);
         e2[i] = 34'(p[6+i]) - 34'(p[i]);
      end
      cr[0] = 70'(e1[1]) * 70'(e2[2]) - 70'(e1[2]) * 70'(e2[1]);
      cr[1] = 70'(e1[2]) * 70'(e2[0]) - 70'(e1[0]) * 70'(e2[2]);
      cr[2] = 70'(e1[0]) * 70'(e2[1]) - 70'(e1[1]) * 70'(e2[0]);
      maxlen = 0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = cr[i] < 0 ? 70'(-cr[i]) : 70'(cr[i]);
         for (int b = 69; b >= 0; b--)
            if (mag[i][b]) begin
               if (b + 1 > maxlen) maxlen = b + 1;
               break;
            end
      end
      r = '{a: 0, b: 0, c: 0, d: 0, degen: 1'b1};
      if (maxlen == 0) return r;
      r.degen = 1'b0;
      sh = 30 - maxlen;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = sh >= 0 ? 64'(mag[i] << sh) : 64'(mag[i] >> (-sh));
         n[i] = cr[i] < 0 ? -$signed(m[i]) : $signed(m[i]);
         sum += m[i] * m[i];
      end
      // bit-by-bit integer square root
      root = 0;
      rem = sum;
      bitv = 64'd1 << 62;
      while (bitv > rem) bitv >>= 2;
      while (bitv != 0) begin
         if (rem >= root + bitv) begin
            rem -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      for (int i = 0; i < 3; i++) begin
         q = ((128'(m[i]) << 30) + (128'(root) >> 1) + 128'(root[0])) / 128'(root);
         // round half away: add exactly half of root, then floor; matches 2r >= den
         q = ((128'(m[i]) << 30) * 2 + 128'(root)) / (128'(root) * 2);
         if (i == 0) r.a = n[i] < 0 ? -32'(q) : 32'(q);
         if (i == 1) r.b = n[i] < 0 ? -32'(q) : 32'(q);
         if (i == 2) r.c = n[i] < 0 ? -32'(q) : 32'(q);
      end
      dot = 128'(n[0]) * 128'(p[0]) + 128'(n[1]) * 128'(p[1]) + 128'(n[2]) * 128'(p[2]);
      dmag = dot < 0 ? 128'(-dot) : 128'(dot);
      rr = 128'(root) << (COORD_FRAC_BITS > D_FRAC_BITS ? COORD_FRAC_BITS - D_FRAC_BITS : 0);
      q = ((dmag << (D_FRAC_BITS >= COORD_FRAC_BITS ? D_FRAC_BITS - COORD_FRAC_BITS : 0)) * 2
           + rr) / (rr * 2);
      if (dot > 0) begin
         lim = 128'd1 << 47;
         if (q > lim) q = lim;
         r.d = -48'(q);
      end else begin
         lim = (128'd1 << 47) - 1;
         if (q > lim) q = lim;
         r.d = 48'(q);
      end
      return r;
   endfunction

   class plane_scoreboard;
      plane_type pending[$];
      int errors;
      int checked;
      int degens;

      function void note_triple(logic [287:0] pts);
         pending = {pending, plane_of(pts)};
      endfunction

      function void check_plane(logic [143:0] data, logic user);
         plane_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h/%b", $time, data, user);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (user) degens++;
         if (data[31:0] !== e.a) begin
            $display("%0t: a_coef expected %h actual %h", $time, e.a, data[31:0]);
            errors++;
         end
         if (data[63:32] !== e.b) begin
            $display("%0t: b_coef expected %h actual %h", $time, e.b, data[63:32]);
            errors++;
         end
         if (data[95:64] !== e.c) begin
            $display("%0t: c_coef expected %h actual %h", $time, e.c, data[95:64]);
            errors++;
         end
         if (data[143:96] !== e.d) begin
            $display("%0t: d_coef expected %h actual %h", $time, e.d, data[143:96]);
            errors++;
         end
         if (user !== e.degen) begin
            $display("%0t: degenerate expected %b actual %b", $time, e.degen, user);
            errors++;
         end
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [287:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic         rsp_tuser;

   plane_scoreboard board = new();
   bit   calm;          // no idling in the closing stretch
   bit   hold_off;      // long receiver stall, filling the pipeline
   int   hold_done;
   longint cycles;

   plane_from_three_points_top i_dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog; count cycles and end the run on a timeout.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Score every accepted input and result at the edge that moves it.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) board.note_triple(req_tdata);
      if (!reset && rsp_tvalid && rsp_tready) board.check_plane(rsp_tdata, rsp_tuser);
   end

   // Receiver: random stall bursts, one long hold-off, none at the end.
   initial begin
      int gap;
      @(posedge clock iff !reset);
      forever begin
         if (hold_off) begin
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_done = 1;
            hold_off = 0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 17);
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($signed($urandom_range(0, 64)) - 32);
         3: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
         default: return $urandom();
      endcase
   endfunction

   // Offer one triple and hold it until accepted; idle at random before it.
   task automatic send_triple(input logic [287:0] pts);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 17);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pts;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [287:0] pack_points(input logic [31:0] c [9]);
      logic [287:0] v;
      for (int i = 0; i < 9; i++) v[32*i +: 32] = c[i];
      return v;
   endfunction

   initial begin
      logic [31:0] c [9];
      logic [31:0] s;
      cycles = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: coincident, collinear, unit axes, extremes, alternating bits.
      c = '{default: 32'h0};
      send_triple(pack_points(c));
      c = '{default: 32'h8000_0000};
      send_triple(pack_points(c));
      c = '{32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h1_0000, 32'h1_0000,
            32'h2_0000, 32'h2_0000, 32'h2_0000};
      send_triple(pack_points(c));
      c = '{32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h0, 32'h0, 32'h0, 32'h1_0000, 32'h0};
      send_triple(pack_points(c));
      c = '{32'h0, 32'h0, 32'h5_0000, 32'h0, 32'h1_0000, 32'h5_0000,
            32'h0, 32'h0, 32'h6_0000};
      send_triple(pack_points(c));
      c = '{32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000};
      send_triple(pack_points(c));
      c = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
            32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff};
      send_triple(pack_points(c));
      c = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
            32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff};
      send_triple(pack_points(c));
      c = '{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
            32'haaaa_aaaa, 32'h0000_0001, 32'hffff_ffff, 32'h1234_5678};
      send_triple(pack_points(c));
      c = '{32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0};
      send_triple(pack_points(c));
      c = '{32'hffff_ffff, 32'h0, 32'h0, 32'h0, 32'h1, 32'h0, 32'h0, 32'h0, 32'h1};
      send_triple(pack_points(c));

      // Random triples; a long receiver stall partway through.
      for (int k = 0; k < 940; k++) begin
         if (k == 200) hold_off = 1;
         if (k == 800) calm = 1;
         for (int i = 0; i < 9; i++) c[i] = pick_coord();
         if ($urandom_range(0, 9) == 0) begin
            // collinear: p2 = p0 + 2*(p1 - p0) with small steps
            for (int i = 0; i < 3; i++) begin
               s = 32'($signed($urandom_range(0, 2000)) - 1000);
               c[3+i] = c[i] + s;
               c[6+i] = c[i] + 2 * s;
            end
         end
         send_triple(pack_points(c));
      end
      req_tvalid <= 1'b0;

      while (board.pending.size() != 0) @(posedge clock);
      repeat (LAT + 20) @(posedge clock);
      $display("Checked %0d planes (%0d degenerate), incl. extremes and a %0s stall.",
               board.checked, board.degens, hold_done ? "long" : "missing long");
      if (board.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
